>>> rtl/core/ira_pkg.sv
`timescale 1ns / 1ps
package ira_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int RADIX_W        = 6;
  localparam int RADIX_MIN      = 2;
  localparam int RADIX_MAX      = 36;
  localparam int RADIX_RESET    = 10;
  localparam int DEC_DIGITS     = 10;
  localparam int CHAR_W         = 7;
  localparam int CHAR_ZERO      = 48;
  localparam int CHAR_UPPER_A   = 65;
  localparam int CHAR_ERROR     = 63;

  // one control word of the microprogram, as seen by the datapath
  typedef struct packed {
    logic in_ready;
    logic div_init;
    logic div_step;
    logic push;
    logic pop;
    logic emit;
    logic emit_err;
  } ira_ctrl_t;

  // datapath flags tested by conditional jumps
  typedef struct packed {
    logic radix_bad;
    logic bits_left;
    logic quot_nz;
    logic out_busy;
    logic ptr_nz;
  } ira_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    if (d < RADIX_W'(DEC_DIGITS)) begin
      return CHAR_W'(CHAR_ZERO + int'(d));
    end
    return CHAR_W'(CHAR_UPPER_A + int'(d) - DEC_DIGITS);
  endfunction

endpackage

>>> rtl/core/ira_ram.sv
`timescale 1ns / 1ps
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ira_dp.sv
`timescale 1ns / 1ps
module ira_dp import ira_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ira_ctrl_t             ctrl,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_data,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_last,
  output ira_stat_t             stat
);

  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int PTR_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    rem;
  logic [RADIX_W-1:0]    rem_next;
  logic [CNT_W-1:0]      bitcnt;
  logic [PTR_W-1:0]      ptr;
  logic [PTR_W-1:0]      ptr_dec;
  logic [RADIX_W:0]      trial;
  logic [RADIX_W:0]      diff;
  logic                  ge;
  logic [RADIX_W-1:0]    rdata;

  // restoring divide, one quotient bit per cycle, quotient shifts into value
  assign trial    = {rem, value[VALUE_BITS-1]};
  assign ge       = trial >= {1'b0, radix};
  assign diff     = trial - {1'b0, radix};
  assign rem_next = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  assign ptr_dec  = ptr - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_W'(RADIX_RESET);
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix <= cfg_data;
      end
      if (ctrl.in_ready && in_valid) begin
        ptr <= '0;
      end else if (ctrl.push) begin
        ptr <= ptr + 1'b1;
      end else if (ctrl.pop) begin
        ptr <= ptr_dec;
      end
      if (ctrl.emit || ctrl.emit_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_ready && in_valid) begin
      value <= in_data;
    end else if (ctrl.div_step) begin
      value <= {value[VALUE_BITS-2:0], ge};
    end
    if (ctrl.div_init) begin
      rem    <= '0;
      bitcnt <= CNT_W'(VALUE_BITS - 1);
    end else if (ctrl.div_step) begin
      rem    <= rem_next;
      bitcnt <= bitcnt - 1'b1;
    end
    if (ctrl.emit) begin
      out_char <= digit_to_ascii(rdata);
      out_last <= (ptr == '0);
    end else if (ctrl.emit_err) begin
      out_char <= CHAR_W'(CHAR_ERROR);
      out_last <= 1'b1;
    end
  end

  // digit stack, least significant digit pushed first
  ira_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (ptr[ADDR_W-1:0]),
    .wdata (rem),
    .re    (ctrl.pop),
    .raddr (ptr_dec[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    stat.radix_bad = (radix < RADIX_W'(RADIX_MIN)) || (radix > RADIX_W'(RADIX_MAX));
    stat.bits_left = bitcnt != '0;
    stat.quot_nz   = value != '0;
    stat.out_busy  = out_valid && !out_ready;
    stat.ptr_nz    = ptr != '0;
  end

endmodule

>>> rtl/core/ira_seq.sv
`timescale 1ns / 1ps
module ira_seq import ira_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  ira_stat_t stat,
  output ira_ctrl_t ctrl
);

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK    = 4'd1;
  localparam logic [STEP_W-1:0] S_DIV_INIT = 4'd2;
  localparam logic [STEP_W-1:0] S_DIV_STEP = 4'd3;
  localparam logic [STEP_W-1:0] S_PUSH     = 4'd4;
  localparam logic [STEP_W-1:0] S_POP      = 4'd5;
  localparam logic [STEP_W-1:0] S_WAIT     = 4'd6;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd7;
  localparam logic [STEP_W-1:0] S_DONE     = 4'd8;
  localparam logic [STEP_W-1:0] S_ERR_WAIT = 4'd9;
  localparam logic [STEP_W-1:0] S_ERR_EMIT = 4'd10;

  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_IN_IDLE   = 3'd1;
  localparam logic [2:0] C_RADIX_BAD = 3'd2;
  localparam logic [2:0] C_BITS_LEFT = 3'd3;
  localparam logic [2:0] C_QUOT_NZ   = 3'd4;
  localparam logic [2:0] C_OUT_BUSY  = 3'd5;
  localparam logic [2:0] C_PTR_NZ    = 3'd6;
  localparam logic [2:0] C_ALWAYS    = 3'd7;

  typedef struct packed {
    ira_ctrl_t         ctrl;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;
  logic              taken;

  // control store: in_ready, div_init, div_step, push, pop, emit, emit_err
  always_comb begin
    case (step)
      S_IDLE:     uw = '{7'b1000000, C_IN_IDLE,   S_IDLE};
      S_CHECK:    uw = '{7'b0000000, C_RADIX_BAD, S_ERR_WAIT};
      S_DIV_INIT: uw = '{7'b0100000, C_NEVER,     S_IDLE};
      S_DIV_STEP: uw = '{7'b0010000, C_BITS_LEFT, S_DIV_STEP};
      S_PUSH:     uw = '{7'b0001000, C_QUOT_NZ,   S_DIV_INIT};
      S_POP:      uw = '{7'b0000100, C_NEVER,     S_IDLE};
      S_WAIT:     uw = '{7'b0000000, C_OUT_BUSY,  S_WAIT};
      S_EMIT:     uw = '{7'b0000010, C_PTR_NZ,    S_POP};
      S_DONE:     uw = '{7'b0000000, C_ALWAYS,    S_IDLE};
      S_ERR_WAIT: uw = '{7'b0000000, C_OUT_BUSY,  S_ERR_WAIT};
      S_ERR_EMIT: uw = '{7'b0000001, C_ALWAYS,    S_IDLE};
      default:    uw = '{7'b0000000, C_ALWAYS,    S_IDLE};
    endcase
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:     taken = 1'b0;
      C_IN_IDLE:   taken = !in_valid;
      C_RADIX_BAD: taken = stat.radix_bad;
      C_BITS_LEFT: taken = stat.bits_left;
      C_QUOT_NZ:   taken = stat.quot_nz;
      C_OUT_BUSY:  taken = stat.out_busy;
      C_PTR_NZ:    taken = stat.ptr_nz;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? uw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl = uw.ctrl;

endmodule

>>> rtl/core/integer_to_radix_ascii.sv
`timescale 1ns / 1ps
// Converts one unsigned integer per input item into ASCII digits in the
// radix held in the 6-bit config register (reset 10, valid 2 to 36), most
// significant digit first, 'A'-'Z' above 9, no leading zeros; tlast marks
// the final digit. An out-of-range radix yields a single '?' with tlast.
// A small microprogram sequences a bit-serial restoring divider and a digit
// stack RAM. Every digit is divided out, one quotient bit per cycle, and
// pushed onto the stack; the digits are then popped and emitted, each one
// waiting while the output is stalled ('?' likewise). One item is converted
// at a time. Write the radix only while the block is idle.
module integer_to_radix_ascii import ira_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [RADIX_W-1:0]                 cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,  // number_in
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((CHAR_W+7)/8)*8-1:0]        m_tdata,  // digit_char
  output logic                               m_tlast   // last_digit
);

  localparam int OUT_W = ((CHAR_W + 7) / 8) * 8;

  ira_ctrl_t         ctrl;
  ira_stat_t         stat;
  logic [CHAR_W-1:0] out_char;

  ira_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ira_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata[VALUE_BITS-1:0]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_char  (out_char),
    .out_last  (m_tlast),
    .stat      (stat)
  );

  assign s_tready = ctrl.in_ready;
  assign m_tdata  = {{(OUT_W - CHAR_W){1'b0}}, out_char};

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit || ctrl.emit_err) |-> !(m_tvalid && !m_tready))
    else $error("output register loaded while an item is still pending");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> stat.ptr_nz)
    else $error("digit stack popped while empty");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again before conversion started");

endmodule
